### hdl/kaac_pkg.sv
// ----------------------------------------------------------------------------
// kaac_pkg
// Shared types, command codes and the CRC-8 byte step of the keyed alarm
// arming controller.
// ----------------------------------------------------------------------------
package kaac_pkg;

    // Item command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_KEY    = 3'd1;
    localparam logic [2:0] CMD_ADD    = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_ARM    = 3'd4;
    localparam logic [2:0] CMD_DISARM = 3'd5;
    localparam logic [2:0] CMD_ALARM  = 3'd6;

    // Access report codes
    localparam logic [1:0] ACC_NONE    = 2'd0;
    localparam logic [1:0] ACC_GRANTED = 2'd1;
    localparam logic [1:0] ACC_DENIED  = 2'd2;

    typedef enum logic [1:0] {
        ST_DISARMED = 2'd0,
        ST_ARMING   = 2'd1,
        ST_ARMED    = 2'd2,
        ST_ALARM    = 2'd3
    } alarm_t;

    localparam int          KEY_W         = 64;
    localparam int          DELAY_W       = 16;
    localparam int          ELAPSED_W     = 26;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam int          MS_PER_S      = 1000;
    localparam logic [DELAY_W-1:0] KEY_DELAY_RST = 16'd10;
    localparam int          CRC_BYTES     = 7;
    localparam logic [7:0]  CRC8_POLY     = 8'h8C;   // x^8+x^5+x^4+1, reflected

    typedef enum logic [1:0] {
        TBL_FIND   = 2'd0,
        TBL_ADD    = 2'd1,
        TBL_REMOVE = 2'd2
    } tbl_op_t;

    typedef struct packed {
        logic    start;
        tbl_op_t op;
    } tbl_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } tbl_rsp_t;

    // One byte of the Dallas CRC-8, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc_in;
        d = data;
        for (int b = 0; b < 8; b++) begin
            mix = c[0] ^ d[0];
            c   = c >> 1;
            if (mix) begin
                c = c ^ CRC8_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

### hdl/keyed_alarm_arming_controller.sv
// ----------------------------------------------------------------------------
// keyed_alarm_arming_controller
// Four-state alarm controller with a RAM-backed table of authorized keys.
// ----------------------------------------------------------------------------
// Tick, arm, disarm, alarm and unused codes finish in S_EXEC; add and remove
//   go to the table; a key runs the CRC over bytes 0..6, then a table scan if
//   byte 7 matches, else finishes in S_EXEC.
// One item in flight; the next is taken in the cycle after the result is registered.
// Reset (async, rst_n low): disarmed, empty table, timer and arming limit zero,
//   key arming delay 10 s. The RAM is not cleared.
// ----------------------------------------------------------------------------
module keyed_alarm_arming_controller
    import kaac_pkg::*;
#(
    parameter int KEY_SLOTS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DELAY_W-1:0] cfg_data,
    // input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic [KEY_W-1:0]   key_id,
    input  logic [DELAY_W-1:0] arm_delay_s,
    // results
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               status_changed,
    output logic [1:0]         access,
    output logic               op_ok,
    output logic [3:0]         key_count
);

    localparam int CW = $clog2(KEY_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CRC,
        S_TABLE,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [2:0]           cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [DELAY_W-1:0]   delay_reg;
    logic [DELAY_W-1:0]   cfg_delay_reg;
    alarm_t               alarm_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] limit_reg;
    logic [7:0]           crc_reg;
    logic [2:0]           byte_cnt_reg;
    tbl_req_t             tbl_req_reg;
    logic                 changed_reg;
    logic [1:0]           acc_reg;
    logic                 ok_reg;
    logic                 out_valid_reg;
    alarm_t               status_reg;
    logic                 status_changed_reg;
    logic [1:0]           access_reg;
    logic                 op_ok_reg;
    logic [3:0]           key_count_reg;

    tbl_rsp_t             tbl_rsp;
    logic [CW-1:0]        tbl_count;

    alarm_t               alarm_next;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic [ELAPSED_W-1:0] limit_next;
    logic [1:0]           acc_next;
    logic                 ok_next;
    logic                 arm_req;
    logic [DELAY_W-1:0]   arm_delay;
    logic [7:0]           crc_next;

    kaac_key_table #(
        .SLOTS (KEY_SLOTS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req_reg),
        .key   (key_reg),
        .rsp   (tbl_rsp),
        .count (tbl_count)
    );

    assign crc_next = crc8_byte(crc_reg, key_reg[{byte_cnt_reg, 3'b000} +: 8]);

    // Effect of the current item, applied when it finishes
    always_comb
    begin
        alarm_next   = alarm_reg;
        elapsed_next = elapsed_reg;
        limit_next   = limit_reg;
        acc_next     = ACC_NONE;
        ok_next      = 1'b0;
        arm_req      = 1'b0;
        arm_delay    = delay_reg;
        case (cmd_reg) inside
            CMD_TICK:
            begin
                if (elapsed_reg != ELAPSED_MAX) begin
                    elapsed_next = elapsed_reg + ELAPSED_W'(1);
                end
                if ((alarm_reg == ST_ARMING) && (elapsed_next >= limit_reg)) begin
                    alarm_next = ST_ARMED;
                end
            end
            CMD_KEY:
            begin
                // finished in S_EXEC only when the CRC failed
                if (state_reg == S_TABLE) begin
                    if (tbl_rsp.hit) begin
                        acc_next = ACC_GRANTED;
                        if ((alarm_reg == ST_ARMED) || (alarm_reg == ST_ALARM)) begin
                            alarm_next = ST_DISARMED;
                        end else begin
                            arm_req   = 1'b1;
                            arm_delay = cfg_delay_reg;
                        end
                    end else begin
                        acc_next = ACC_DENIED;
                        if (alarm_reg == ST_ARMED) begin
                            alarm_next = ST_ALARM;
                        end
                    end
                end
            end
            CMD_ADD, CMD_REMOVE:
            begin
                ok_next = tbl_rsp.hit;
            end
            CMD_ARM:
            begin
                arm_req = 1'b1;
            end
            CMD_DISARM:
            begin
                alarm_next = ST_DISARMED;
            end
            CMD_ALARM:
            begin
                alarm_next = ST_ALARM;
            end
            default:
            begin
                alarm_next = alarm_reg;
            end
        endcase
        // arming is ignored while already armed
        if (arm_req && (alarm_reg != ST_ARMED)) begin
            limit_next   = ELAPSED_W'(arm_delay) * ELAPSED_W'(MS_PER_S);
            elapsed_next = '0;
            alarm_next   = (arm_delay != '0) ? ST_ARMING : ST_ARMED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cfg_delay_reg <= KEY_DELAY_RST;
            alarm_reg     <= ST_DISARMED;
            elapsed_reg   <= '0;
            limit_reg     <= '0;
            tbl_req_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            tbl_req_reg.start <= 1'b0;
            if (cfg_valid) begin
                cfg_delay_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid) begin
                        cmd_reg   <= cmd;
                        key_reg   <= key_id;
                        delay_reg <= arm_delay_s;
                        case (cmd)
                            CMD_KEY:
                            begin
                                crc_reg      <= '0;
                                byte_cnt_reg <= '0;
                                state_reg    <= S_CRC;
                            end
                            CMD_ADD:
                            begin
                                tbl_req_reg <= '{start: 1'b1, op: TBL_ADD};
                                state_reg   <= S_TABLE;
                            end
                            CMD_REMOVE:
                            begin
                                tbl_req_reg <= '{start: 1'b1, op: TBL_REMOVE};
                                state_reg   <= S_TABLE;
                            end
                            default:
                            begin
                                state_reg <= S_EXEC;
                            end
                        endcase
                    end
                end
                S_CRC:
                begin
                    crc_reg      <= crc_next;
                    byte_cnt_reg <= byte_cnt_reg + 3'd1;
                    if (byte_cnt_reg == 3'(CRC_BYTES - 1)) begin
                        if (crc_next == key_reg[63:56]) begin
                            tbl_req_reg <= '{start: 1'b1, op: TBL_FIND};
                            state_reg   <= S_TABLE;
                        end else begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_EXEC, S_TABLE:
                begin
                    if ((state_reg == S_EXEC) || tbl_rsp.done) begin
                        alarm_reg   <= alarm_next;
                        elapsed_reg <= elapsed_next;
                        limit_reg   <= limit_next;
                        changed_reg <= alarm_next != alarm_reg;
                        acc_reg     <= acc_next;
                        ok_reg      <= ok_next;
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready) begin
                        status_reg         <= alarm_reg;
                        status_changed_reg <= changed_reg;
                        access_reg         <= acc_reg;
                        op_ok_reg          <= ok_reg;
                        key_count_reg      <= 4'(tbl_count);
                        out_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready      = 1'b1;
    assign in_ready       = state_reg == S_IDLE;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign status_changed = status_changed_reg;
    assign access         = access_reg;
    assign op_ok          = op_ok_reg;
    assign key_count      = key_count_reg;

endmodule

### hdl/kaac_key_table.sv
// ----------------------------------------------------------------------------
// kaac_key_table
// Authorized key store: one synchronous RAM plus a sequencer that appends,
// scans for a key, and compacts the table after a removal.
// ----------------------------------------------------------------------------
module kaac_key_table
    import kaac_pkg::*;
#(
    parameter int SLOTS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tbl_req_t                      req,
    input  logic [KEY_W-1:0]              key,
    output tbl_rsp_t                      rsp,
    output logic [$clog2(SLOTS+1)-1:0]    count
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    typedef enum logic [1:0] {
        T_IDLE,
        T_SEARCH,
        T_SHIFT
    } tstate_t;

    tstate_t          state_reg;
    tbl_op_t          op_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    scan_reg;
    logic [CW-1:0]    nxt_reg;
    logic [AW-1:0]    cmp_reg;
    logic [AW-1:0]    wr_reg;
    logic             pend_reg;
    tbl_rsp_t         rsp_reg;

    logic [KEY_W-1:0] mem [SLOTS];
    logic [KEY_W-1:0] rd_data_reg;

    logic             match;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic [CW-1:0]    nxt_dec;

    assign match   = pend_reg && (rd_data_reg == key);
    assign nxt_dec = nxt_reg - CW'(1);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = scan_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = key;
        unique case (state_reg)
            T_IDLE:
            begin
                wr_en = req.start && (req.op == TBL_ADD) && (count_reg < SLOTS_C);
            end
            T_SEARCH:
            begin
                rd_en = !match && (scan_reg < count_reg);
            end
            T_SHIFT:
            begin
                // read entry j+2 while the word read last cycle, entry j+1, lands in j
                rd_en   = nxt_reg < count_reg;
                rd_addr = nxt_reg[AW-1:0];
                wr_en   = pend_reg;
                wr_addr = wr_reg;
                wr_data = rd_data_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= T_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            rsp_reg   <= '0;
        end else begin
            rsp_reg.done <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (req.start) begin
                        op_reg   <= req.op;
                        scan_reg <= '0;
                        pend_reg <= 1'b0;
                        if (req.op == TBL_ADD) begin
                            rsp_reg.done <= 1'b1;
                            rsp_reg.hit  <= count_reg < SLOTS_C;
                            if (count_reg < SLOTS_C) begin
                                count_reg <= count_reg + CW'(1);
                            end
                        end else begin
                            state_reg <= T_SEARCH;
                        end
                    end
                end
                T_SEARCH:
                begin
                    if (match) begin
                        if (op_reg == TBL_REMOVE) begin
                            nxt_reg   <= CW'(cmp_reg) + CW'(1);
                            pend_reg  <= 1'b0;
                            state_reg <= T_SHIFT;
                        end else begin
                            rsp_reg.done <= 1'b1;
                            rsp_reg.hit  <= 1'b1;
                            state_reg    <= T_IDLE;
                        end
                    end else if (scan_reg < count_reg) begin
                        pend_reg <= 1'b1;
                        cmp_reg  <= scan_reg[AW-1:0];
                        scan_reg <= scan_reg + CW'(1);
                    end else begin
                        rsp_reg.done <= 1'b1;
                        rsp_reg.hit  <= 1'b0;
                        state_reg    <= T_IDLE;
                    end
                end
                T_SHIFT:
                begin
                    if (nxt_reg < count_reg) begin
                        pend_reg <= 1'b1;
                        wr_reg   <= nxt_dec[AW-1:0];
                        nxt_reg  <= nxt_reg + CW'(1);
                    end else begin
                        pend_reg     <= 1'b0;
                        count_reg    <= count_reg - CW'(1);
                        rsp_reg.done <= 1'b1;
                        rsp_reg.hit  <= 1'b1;
                        state_reg    <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign rsp   = rsp_reg;
    assign count = count_reg;

endmodule

### hdl/kaac_checker.sv
// ----------------------------------------------------------------------------
// kaac_checker
// Port-level checks on the result words of the keyed alarm arming controller.
// ----------------------------------------------------------------------------
module kaac_checker
    import kaac_pkg::*;
#(
    parameter int KEY_SLOTS = 10
) (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic       status_changed,
    input logic [1:0] access,
    input logic       op_ok,
    input logic [3:0] key_count
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(access) && $stable(op_ok) && $stable(key_count))
        else $error("result word changed while stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(key_count) <= KEY_SLOTS))
        else $error("key count above table size");

    // table ops never report access, key events never report op_ok
    a_ok_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_ok |-> access == ACC_NONE)
        else $error("op_ok together with an access report");

    a_denied_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (access == ACC_DENIED) && status_changed |-> status == ST_ALARM)
        else $error("denied key changed status to other than alarm");

    a_granted_nochange: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (access == ACC_GRANTED) |-> status != ST_ALARM)
        else $error("granted key left the alarm raised");

endmodule

bind keyed_alarm_arming_controller kaac_checker #(
    .KEY_SLOTS (KEY_SLOTS)
) u_kaac_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .status_changed (status_changed),
    .access         (access),
    .op_ok          (op_ok),
    .key_count      (key_count)
);
